// ===== sv/atw_pkg.sv =====
// ----------------------------------------------------------------------------
// atw_pkg: shared types and constants of the ANSI text terminal writer
// Character codes, SGR codes, result field widths, configuration register
// indexes and the operation codes of the shared arithmetic unit.
// ----------------------------------------------------------------------------
package atw_pkg;

    // Field widths of the character and cell channels.
    localparam int CH_W    = 8;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int COLOR_W = 4;

    // Cursor and parameter value width.
    localparam int POS_W = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_FG = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_BG = 1'd1;

    // Reset values of the default colors.
    localparam logic [COLOR_W-1:0] DEF_FG_RST = 4'd8;
    localparam logic [COLOR_W-1:0] DEF_BG_RST = 4'd0;

    // Cell request kinds.
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SCROLL = 1'b1;

    // Control characters.
    localparam logic [CH_W-1:0] CH_NUL  = 8'h00;
    localparam logic [CH_W-1:0] CH_BS   = 8'h08;
    localparam logic [CH_W-1:0] CH_LF   = 8'h0A;
    localparam logic [CH_W-1:0] CH_CR   = 8'h0D;
    localparam logic [CH_W-1:0] CH_ESC  = 8'h1B;
    localparam logic [CH_W-1:0] CH_LBR  = 8'h5B;
    localparam logic [CH_W-1:0] CH_SEMI = 8'h3B;
    localparam logic [CH_W-1:0] CH_0    = 8'h30;
    localparam logic [CH_W-1:0] CH_9    = 8'h39;

    // Final bytes of the supported sequences.
    localparam logic [CH_W-1:0] CH_SGR     = 8'h6D; // m
    localparam logic [CH_W-1:0] CH_CUP     = 8'h48; // H
    localparam logic [CH_W-1:0] CH_HVP     = 8'h66; // f
    localparam logic [CH_W-1:0] CH_CUU     = 8'h41; // A
    localparam logic [CH_W-1:0] CH_CUD     = 8'h42; // B
    localparam logic [CH_W-1:0] CH_CUF     = 8'h43; // C
    localparam logic [CH_W-1:0] CH_CUB     = 8'h44; // D
    localparam logic [CH_W-1:0] CH_CHA     = 8'h47; // G

    // SGR parameter values.
    localparam logic [POS_W-1:0] SGR_RESET      = 8'd0;
    localparam logic [POS_W-1:0] SGR_FG_DEFAULT = 8'd39;
    localparam logic [POS_W-1:0] SGR_BG_DEFAULT = 8'd49;
    localparam logic [POS_W-1:0] SGR_FG_FIRST   = 8'd30;
    localparam logic [POS_W-1:0] SGR_FG_LAST    = 8'd37;
    localparam logic [POS_W-1:0] SGR_BG_FIRST   = 8'd40;
    localparam logic [POS_W-1:0] SGR_BG_LAST    = 8'd47;

    // Decimal radix of sequence parameters.
    localparam logic [3:0] DIGIT_RADIX = 4'd10;

    // Operations of the shared arithmetic unit.
    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MAC10
    } t_alu_op;

    // Commands to the parameter store.
    typedef struct packed {
        logic clear;
        logic we;
    } t_pst_cmd;

endpackage

// ===== sv/atw_if.sv =====
// ----------------------------------------------------------------------------
// atw_if: channels of the ANSI text terminal writer
// Character input channel and cell request output channel, each with a
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface atw_char_if;
    logic                      valid;
    logic                      ready;
    logic [atw_pkg::CH_W-1:0]  ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface atw_cell_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [atw_pkg::ROW_W-1:0]    row;
    logic [atw_pkg::COL_W-1:0]    col;
    logic [atw_pkg::CH_W-1:0]     glyph;
    logic [atw_pkg::COLOR_W-1:0]  fg_color;
    logic [atw_pkg::COLOR_W-1:0]  bg_color;
    logic                         last;

    modport source (output valid, output kind, output row, output col, output glyph,
                    output fg_color, output bg_color, output last, input ready);
    modport sink   (input valid, input kind, input row, input col, input glyph,
                    input fg_color, input bg_color, input last, output ready);
endinterface

// ===== sv/atw_alu.sv =====
// ----------------------------------------------------------------------------
// atw_alu: shared arithmetic unit
// Add, subtract with borrow, and decimal accumulate on 8-bit operands.
// ----------------------------------------------------------------------------
module atw_alu (
    input  atw_pkg::t_alu_op           i_op,
    input  logic [atw_pkg::POS_W-1:0]  i_a,
    input  logic [atw_pkg::POS_W-1:0]  i_b,
    output logic [atw_pkg::POS_W:0]    o_y
);

    localparam int MAC_W = atw_pkg::POS_W + 4;

    logic [MAC_W-1:0] mac;

    // Decimal accumulate: a * 10 + b, kept modulo 256.
    assign mac = MAC_W'(i_a) * MAC_W'(atw_pkg::DIGIT_RADIX) + MAC_W'(i_b);

    // Bit 8 holds the carry of an add or the borrow of a subtract.
    always_comb begin
        case (i_op)
            atw_pkg::ALU_ADD:   o_y = {1'b0, i_a} + {1'b0, i_b};
            atw_pkg::ALU_SUB:   o_y = {1'b0, i_a} - {1'b0, i_b};
            atw_pkg::ALU_MAC10: o_y = {1'b0, mac[atw_pkg::POS_W-1:0]};
            default:            o_y = '0;
        endcase
    end

endmodule

// ===== sv/atw_param_store.sv =====
// ----------------------------------------------------------------------------
// atw_param_store: escape sequence parameter memory
// One write port and one registered read port. Valid bits make a cleared
// entry read as zero without sweeping the array.
// ----------------------------------------------------------------------------
module atw_param_store #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  atw_pkg::t_pst_cmd           i_cmd,
    input  logic [AW-1:0]               i_waddr,
    input  logic [atw_pkg::POS_W-1:0]   i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [atw_pkg::POS_W-1:0]   o_rdata
);

    logic [atw_pkg::POS_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]          r_valid;
    logic [atw_pkg::POS_W-1:0] r_rdata;

    // Valid bits: cleared by reset and by the start of a new sequence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_valid <= '0;
        end else if (i_cmd.we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    // Storage array.
    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read; an entry that is not valid reads as zero.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_valid[i_raddr] ? r_mem[i_raddr] : '0;
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ansi_text_terminal_writer.sv =====
// ----------------------------------------------------------------------------
// ansi_text_terminal_writer: character stream to cell write requests
// Interprets a byte stream with ANSI cursor and color sequences and issues
// cell writes and scroll-up requests for a text screen.
// ----------------------------------------------------------------------------
// The block takes one character at a time and stays busy until the last
// request that the character causes has been placed in the output register.
// A printable byte, and a line feed that scrolls, can wait on the cell
// channel. A cursor command (H, f, A, B, C, D, G) reads its two parameters
// one after the other through the single read port of the parameter
// memory. An SGR command reads and applies each stored parameter in turn,
// up to the current index, at most MAX_PARAMS of them. All cursor,
// parameter value and color arithmetic goes through one shared arithmetic
// unit. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module ansi_text_terminal_writer #(
    parameter int COLUMNS    = 80,
    parameter int ROWS       = 30,
    parameter int MAX_PARAMS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    atw_char_if.sink                         i_char,
    atw_cell_if.source                       o_cell,
    input  logic                             i_cfg_we,
    input  logic [atw_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [atw_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int PIDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int PW     = atw_pkg::POS_W;

    localparam logic [PW:0]       COL_LIM   = (PW+1)'(COLUMNS);
    localparam logic [PW:0]       ROW_LIM   = (PW+1)'(ROWS);
    localparam logic [PW-1:0]     COL_MAX   = PW'(COLUMNS - 1);
    localparam logic [PW-1:0]     ROW_MAX   = PW'(ROWS - 1);
    localparam logic [PIDX_W-1:0] PIDX_LAST = PIDX_W'(MAX_PARAMS - 1);
    localparam logic [PIDX_W-1:0] PIDX_P0   = PIDX_W'(0);
    localparam logic [PIDX_W-1:0] PIDX_P1   = PIDX_W'(1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIGIT,
        S_SGR_RD,
        S_SGR_AP,
        S_P0,
        S_P1,
        S_SCROLL,
        S_WRITE
    } t_state;

    // Sequencer state and terminal state.
    t_state                          r_state, n_state;
    logic [atw_pkg::CH_W-1:0]        r_ch, n_ch;
    logic [PW-1:0]                   r_col, n_col;
    logic [PW-1:0]                   r_row, n_row;
    logic [atw_pkg::COLOR_W-1:0]     r_fg, n_fg;
    logic [atw_pkg::COLOR_W-1:0]     r_bg, n_bg;
    logic [atw_pkg::COLOR_W-1:0]     r_def_fg, n_def_fg;
    logic [atw_pkg::COLOR_W-1:0]     r_def_bg, n_def_bg;
    logic [PIDX_W-1:0]               r_pidx, n_pidx;
    logic                            r_in_esc, n_in_esc;
    logic [PIDX_W-1:0]               r_cnt, n_cnt;
    logic [PW-1:0]                   r_p0, n_p0;
    logic                            r_scroll_last, n_scroll_last;

    // Output register.
    logic                            r_o_valid, n_o_valid;
    logic                            r_o_kind, n_o_kind;
    logic [atw_pkg::ROW_W-1:0]       r_o_row, n_o_row;
    logic [atw_pkg::COL_W-1:0]       r_o_col, n_o_col;
    logic [atw_pkg::CH_W-1:0]        r_o_glyph, n_o_glyph;
    logic [atw_pkg::COLOR_W-1:0]     r_o_fg, n_o_fg;
    logic [atw_pkg::COLOR_W-1:0]     r_o_bg, n_o_bg;
    logic                            r_o_last, n_o_last;

    // Shared unit and parameter memory hookup.
    atw_pkg::t_alu_op                alu_op;
    logic [PW-1:0]                   alu_a, alu_b;
    logic [PW:0]                     alu_y;
    atw_pkg::t_pst_cmd               pst_cmd;
    logic [PIDX_W-1:0]               mem_raddr;
    logic [PW-1:0]                   mem_rdata;

    logic                            out_free;
    logic                            wrap;
    logic [PW:0]                     row_next;

    atw_alu u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    atw_param_store #(
        .DEPTH (MAX_PARAMS),
        .AW    (PIDX_W)
    ) u_param_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (pst_cmd),
        .i_waddr (r_pidx),
        .i_wdata (alu_y[PW-1:0]),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign i_char.ready    = (r_state == S_IDLE);
    assign o_cell.valid    = r_o_valid;
    assign o_cell.kind     = r_o_kind;
    assign o_cell.row      = r_o_row;
    assign o_cell.col      = r_o_col;
    assign o_cell.glyph    = r_o_glyph;
    assign o_cell.fg_color = r_o_fg;
    assign o_cell.bg_color = r_o_bg;
    assign o_cell.last     = r_o_last;

    // The output register can take a new request when empty or being drained.
    assign out_free = !r_o_valid || o_cell.ready;

    // Wrap test for a printable byte and the row it lands on.
    assign wrap     = ({1'b0, r_col} >= COL_LIM);
    assign row_next = wrap ? alu_y : {1'b0, r_row};

    // Sequencer next-state logic.
    always_comb begin
        n_state       = r_state;
        n_ch          = r_ch;
        n_col         = r_col;
        n_row         = r_row;
        n_fg          = r_fg;
        n_bg          = r_bg;
        n_def_fg      = r_def_fg;
        n_def_bg      = r_def_bg;
        n_pidx        = r_pidx;
        n_in_esc      = r_in_esc;
        n_cnt         = r_cnt;
        n_p0          = r_p0;
        n_scroll_last = r_scroll_last;
        n_o_valid     = r_o_valid;
        n_o_kind      = r_o_kind;
        n_o_row       = r_o_row;
        n_o_col       = r_o_col;
        n_o_glyph     = r_o_glyph;
        n_o_fg        = r_o_fg;
        n_o_bg        = r_o_bg;
        n_o_last      = r_o_last;
        alu_op        = atw_pkg::ALU_ADD;
        alu_a         = r_row;
        alu_b         = PW'(1);
        pst_cmd       = '0;
        mem_raddr     = r_pidx;

        // A request leaves the output register when the sink takes it.
        if (r_o_valid && o_cell.ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_char.valid) begin
                    n_ch    = i_char.ch;
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                n_state = S_IDLE;
                if (r_ch == atw_pkg::CH_NUL) begin
                    n_state = S_IDLE;
                end else if (r_ch == atw_pkg::CH_BS) begin
                    // Step left, stopping at the first column.
                    alu_op = atw_pkg::ALU_SUB;
                    alu_a  = r_col;
                    if (!alu_y[PW]) begin
                        n_col = alu_y[PW-1:0];
                    end
                end else if (r_ch == atw_pkg::CH_CR) begin
                    n_col = '0;
                end else if (r_ch == atw_pkg::CH_LF) begin
                    // New line; scroll when passing the bottom row.
                    n_col = '0;
                    if (alu_y >= ROW_LIM) begin
                        n_row         = ROW_MAX;
                        n_scroll_last = 1'b1;
                        n_state       = S_SCROLL;
                    end else begin
                        n_row = alu_y[PW-1:0];
                    end
                end else if (r_ch == atw_pkg::CH_ESC) begin
                    n_in_esc      = 1'b1;
                    n_pidx        = '0;
                    pst_cmd.clear = 1'b1;
                end else if (r_in_esc) begin
                    if (r_ch >= atw_pkg::CH_0 && r_ch <= atw_pkg::CH_9) begin
                        // Fetch the current parameter for accumulation.
                        n_state = S_DIGIT;
                    end else if (r_ch == atw_pkg::CH_LBR) begin
                        n_state = S_IDLE;
                    end else if (r_ch == atw_pkg::CH_SEMI) begin
                        n_pidx = (r_pidx == PIDX_LAST) ? '0 : r_pidx + PIDX_W'(1);
                    end else begin
                        n_in_esc = 1'b0;
                        unique case (r_ch) inside
                            atw_pkg::CH_SGR: begin
                                n_cnt   = '0;
                                n_state = S_SGR_RD;
                            end
                            atw_pkg::CH_CUP, atw_pkg::CH_HVP, atw_pkg::CH_CUU,
                            atw_pkg::CH_CUD, atw_pkg::CH_CUF, atw_pkg::CH_CUB,
                            atw_pkg::CH_CHA: begin
                                mem_raddr = PIDX_P0;
                                n_state   = S_P0;
                            end
                            default: n_state = S_IDLE;
                        endcase
                    end
                end else begin
                    // Printable byte: wrap, then scroll if below the screen.
                    if (wrap) begin
                        n_col = '0;
                    end
                    if (row_next >= ROW_LIM) begin
                        n_row         = ROW_MAX;
                        n_scroll_last = 1'b0;
                        n_state       = S_SCROLL;
                    end else begin
                        n_row   = row_next[PW-1:0];
                        n_state = S_WRITE;
                    end
                end
            end

            S_DIGIT: begin
                alu_op     = atw_pkg::ALU_MAC10;
                alu_a      = mem_rdata;
                alu_b      = PW'(r_ch[3:0]);
                pst_cmd.we = 1'b1;
                n_state    = S_IDLE;
            end

            S_SGR_RD: begin
                mem_raddr = r_cnt;
                n_state   = S_SGR_AP;
            end

            S_SGR_AP: begin
                // Color offset from the base code of the range.
                alu_op = atw_pkg::ALU_SUB;
                alu_a  = mem_rdata;
                alu_b  = (mem_rdata >= atw_pkg::SGR_BG_FIRST) ? atw_pkg::SGR_BG_FIRST
                                                              : atw_pkg::SGR_FG_FIRST;
                if (mem_rdata == atw_pkg::SGR_RESET) begin
                    n_fg = r_def_fg;
                    n_bg = r_def_bg;
                end else if (mem_rdata == atw_pkg::SGR_FG_DEFAULT) begin
                    n_fg = r_def_fg;
                end else if (mem_rdata == atw_pkg::SGR_BG_DEFAULT) begin
                    n_bg = r_def_bg;
                end else if (mem_rdata >= atw_pkg::SGR_FG_FIRST &&
                             mem_rdata <= atw_pkg::SGR_FG_LAST) begin
                    n_fg = alu_y[atw_pkg::COLOR_W-1:0];
                end else if (mem_rdata >= atw_pkg::SGR_BG_FIRST &&
                             mem_rdata <= atw_pkg::SGR_BG_LAST) begin
                    n_bg = alu_y[atw_pkg::COLOR_W-1:0];
                end
                if (r_cnt == r_pidx) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt   = r_cnt + PIDX_W'(1);
                    n_state = S_SGR_RD;
                end
            end

            S_P0: begin
                n_p0      = mem_rdata;
                mem_raddr = PIDX_P1;
                n_state   = S_P1;
            end

            S_P1: begin
                // Cursor command with parameter 0 in r_p0 and parameter 1 on the read port.
                n_state = S_IDLE;
                alu_b   = r_p0;
                unique case (r_ch)
                    atw_pkg::CH_CUP: begin
                        if (r_pidx == '0) begin
                            n_col = '0;
                            n_row = '0;
                        end else begin
                            n_col = r_p0;
                            n_row = mem_rdata;
                        end
                    end
                    atw_pkg::CH_HVP: begin
                        n_col = r_p0;
                        n_row = mem_rdata;
                    end
                    atw_pkg::CH_CUU: begin
                        alu_op = atw_pkg::ALU_SUB;
                        n_row  = alu_y[PW] ? '0 : alu_y[PW-1:0];
                    end
                    atw_pkg::CH_CUD: begin
                        n_row = (alu_y > {1'b0, ROW_MAX}) ? ROW_MAX : alu_y[PW-1:0];
                    end
                    atw_pkg::CH_CUF: begin
                        alu_a = r_col;
                        n_col = (alu_y > {1'b0, COL_MAX}) ? COL_MAX : alu_y[PW-1:0];
                    end
                    atw_pkg::CH_CUB: begin
                        alu_op = atw_pkg::ALU_SUB;
                        alu_a  = r_col;
                        n_col  = alu_y[PW] ? '0 : alu_y[PW-1:0];
                    end
                    atw_pkg::CH_CHA: begin
                        n_col = r_p0;
                    end
                    default: n_state = S_IDLE;
                endcase
            end

            S_SCROLL: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = atw_pkg::KIND_SCROLL;
                    n_o_row   = '0;
                    n_o_col   = '0;
                    n_o_glyph = '0;
                    n_o_fg    = '0;
                    n_o_bg    = '0;
                    n_o_last  = r_scroll_last;
                    n_state   = r_scroll_last ? S_IDLE : S_WRITE;
                end
            end

            S_WRITE: begin
                alu_a = r_col;
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = atw_pkg::KIND_WRITE;
                    n_o_row   = r_row[atw_pkg::ROW_W-1:0];
                    n_o_col   = r_col[atw_pkg::COL_W-1:0];
                    n_o_glyph = r_ch;
                    n_o_fg    = r_fg;
                    n_o_bg    = r_bg;
                    n_o_last  = 1'b1;
                    n_col     = alu_y[PW-1:0];
                    n_state   = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase

        // Configuration writes; indexes beyond the list are dropped.
        if (i_cfg_we) begin
            if (i_cfg_idx == atw_pkg::CFG_DEFAULT_FG) begin
                n_def_fg = i_cfg_data;
            end else if (i_cfg_idx == atw_pkg::CFG_DEFAULT_BG) begin
                n_def_bg = i_cfg_data;
            end
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_col     <= '0;
            r_row     <= '0;
            r_fg      <= atw_pkg::DEF_FG_RST;
            r_bg      <= atw_pkg::DEF_BG_RST;
            r_def_fg  <= atw_pkg::DEF_FG_RST;
            r_def_bg  <= atw_pkg::DEF_BG_RST;
            r_pidx    <= '0;
            r_in_esc  <= 1'b0;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_col     <= n_col;
            r_row     <= n_row;
            r_fg      <= n_fg;
            r_bg      <= n_bg;
            r_def_fg  <= n_def_fg;
            r_def_bg  <= n_def_bg;
            r_pidx    <= n_pidx;
            r_in_esc  <= n_in_esc;
            r_cnt     <= n_cnt;
            r_o_valid <= n_o_valid;
        end
        r_ch          <= n_ch;
        r_p0          <= n_p0;
        r_scroll_last <= n_scroll_last;
        r_o_kind      <= n_o_kind;
        r_o_row       <= n_o_row;
        r_o_col       <= n_o_col;
        r_o_glyph     <= n_o_glyph;
        r_o_fg        <= n_o_fg;
        r_o_bg        <= n_o_bg;
        r_o_last      <= n_o_last;
    end

endmodule

// ===== bench/tb_ansi_text_terminal_writer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ansi_text_terminal_writer: self-checking bench of the terminal writer
// Feeds character requests through the input channel and predicts every cell
// write and scroll request in a small screen model class. Each accepted cell
// request is checked field by field against the oldest prediction. The run
// covers directed escape sequences, four color settings and random streams
// under random idling, a long receiver hold-off and a full drain.
// ----------------------------------------------------------------------------
module tb_ansi_text_terminal_writer;

    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 30;
    localparam int PARAM_SLOTS = 8;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT = 5000;
    localparam int PHASE_CHARS = 500;

    // One cell request as seen on the output channel.
    typedef struct packed {
        logic                        kind;
        logic [atw_pkg::ROW_W-1:0]   row;
        logic [atw_pkg::COL_W-1:0]   col;
        logic [atw_pkg::CH_W-1:0]    glyph;
        logic [atw_pkg::COLOR_W-1:0] fg;
        logic [atw_pkg::COLOR_W-1:0] bg;
        logic                        last;
    } t_cell;

    // Screen model: cursor, colors and sequence parser, plus the cells
    // that are still due from the block.
    class t_screen_model;
        int unsigned                 col_pos;
        int unsigned                 row_pos;
        logic [atw_pkg::COLOR_W-1:0] fg_dflt;
        logic [atw_pkg::COLOR_W-1:0] bg_dflt;
        logic [atw_pkg::COLOR_W-1:0] fg_now;
        logic [atw_pkg::COLOR_W-1:0] bg_now;
        logic [7:0]                  seq_param [PARAM_SLOTS];
        int unsigned                 seq_idx;
        bit                          in_seq;
        t_cell                       pending_cells [$];
        int                          errors;
        int                          cells_seen;
        int                          scrolls_seen;

        function new();
            col_pos = 0;
            row_pos = 0;
            fg_dflt = atw_pkg::DEF_FG_RST;
            bg_dflt = atw_pkg::DEF_BG_RST;
            fg_now = atw_pkg::DEF_FG_RST;
            bg_now = atw_pkg::DEF_BG_RST;
            foreach (seq_param[i]) seq_param[i] = '0;
            seq_idx = 0;
            in_seq = 0;
            errors = 0;
            cells_seen = 0;
            scrolls_seen = 0;
        endfunction

        // A register write changes only the defaults, not the current colors.
        function void set_default(logic [atw_pkg::CFG_IDX_W-1:0] idx,
                                  logic [atw_pkg::CFG_DATA_W-1:0] val);
            if (idx == atw_pkg::CFG_DEFAULT_FG) begin
                fg_dflt = val;
            end else if (idx == atw_pkg::CFG_DEFAULT_BG) begin
                bg_dflt = val;
            end
        endfunction

        function void push_cell(logic kind, int unsigned r, int unsigned c,
                                logic [7:0] g, logic [3:0] f, logic [3:0] b, logic l);
            t_cell entry;
            entry.kind = kind;
            entry.row = r[atw_pkg::ROW_W-1:0];
            entry.col = c[atw_pkg::COL_W-1:0];
            entry.glyph = g;
            entry.fg = f;
            entry.bg = b;
            entry.last = l;
            pending_cells.push_back(entry);
        endfunction

        // Walk the stored parameters up to the current index.
        function void apply_colors();
            logic [7:0] p;
            for (int i = 0; i <= seq_idx && i < PARAM_SLOTS; i++) begin
                p = seq_param[i];
                if (p == atw_pkg::SGR_RESET) begin
                    fg_now = fg_dflt;
                    bg_now = bg_dflt;
                end else if (p == atw_pkg::SGR_FG_DEFAULT) begin
                    fg_now = fg_dflt;
                end else if (p == atw_pkg::SGR_BG_DEFAULT) begin
                    bg_now = bg_dflt;
                end else if (p >= atw_pkg::SGR_FG_FIRST && p <= atw_pkg::SGR_FG_LAST) begin
                    fg_now = 4'(p - atw_pkg::SGR_FG_FIRST);
                end else if (p >= atw_pkg::SGR_BG_FIRST && p <= atw_pkg::SGR_BG_LAST) begin
                    bg_now = 4'(p - atw_pkg::SGR_BG_FIRST);
                end
            end
        endfunction

        // One byte inside an escape sequence.
        function void seq_byte(logic [7:0] c);
            int unsigned p0;
            int unsigned p1;
            int unsigned slot;
            p0 = seq_param[0];
            p1 = seq_param[1];
            if (c >= atw_pkg::CH_0 && c <= atw_pkg::CH_9) begin
                slot = seq_idx % PARAM_SLOTS;
                seq_param[slot] = 8'(seq_param[slot] * atw_pkg::DIGIT_RADIX +
                                     (c - atw_pkg::CH_0));
                return;
            end
            if (c == atw_pkg::CH_LBR) return;
            if (c == atw_pkg::CH_SEMI) begin
                seq_idx++;
                if (seq_idx >= PARAM_SLOTS) seq_idx = 0;
                return;
            end
            in_seq = 0;
            case (c)
                atw_pkg::CH_SGR: apply_colors();
                atw_pkg::CH_CUP: begin
                    if (seq_idx == 0) begin
                        col_pos = 0;
                        row_pos = 0;
                    end else begin
                        col_pos = p0;
                        row_pos = p1;
                    end
                end
                atw_pkg::CH_HVP: begin
                    col_pos = p0;
                    row_pos = p1;
                end
                atw_pkg::CH_CUU: row_pos = (row_pos > p0) ? row_pos - p0 : 0;
                atw_pkg::CH_CUD: begin
                    row_pos += p0;
                    if (row_pos > SCREEN_ROWS - 1) row_pos = SCREEN_ROWS - 1;
                end
                atw_pkg::CH_CUF: begin
                    col_pos += p0;
                    if (col_pos > SCREEN_COLS - 1) col_pos = SCREEN_COLS - 1;
                end
                atw_pkg::CH_CUB: col_pos = (col_pos > p0) ? col_pos - p0 : 0;
                atw_pkg::CH_CHA: col_pos = p0;
                default: ;
            endcase
        endfunction

        // Predict the cell requests caused by one accepted character.
        function void take_char(logic [7:0] c);
            if (c == atw_pkg::CH_NUL) return;
            if (c == atw_pkg::CH_BS) begin
                if (col_pos > 0) col_pos--;
                return;
            end
            if (c == atw_pkg::CH_CR) begin
                col_pos = 0;
                return;
            end
            if (c == atw_pkg::CH_LF) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= SCREEN_ROWS) begin
                    row_pos = SCREEN_ROWS - 1;
                    push_cell(atw_pkg::KIND_SCROLL, 0, 0, 0, 0, 0, 1'b1);
                end
                return;
            end
            if (c == atw_pkg::CH_ESC) begin
                in_seq = 1;
                seq_idx = 0;
                foreach (seq_param[i]) seq_param[i] = '0;
                return;
            end
            if (in_seq) begin
                seq_byte(c);
                return;
            end
            // Printable byte: wrap, then scroll, then write.
            if (col_pos >= SCREEN_COLS) begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos >= SCREEN_ROWS) begin
                row_pos = SCREEN_ROWS - 1;
                push_cell(atw_pkg::KIND_SCROLL, 0, 0, 0, 0, 0, 1'b0);
            end
            push_cell(atw_pkg::KIND_WRITE, row_pos, col_pos, c, fg_now, bg_now, 1'b1);
            col_pos++;
        endfunction

        // Compare one accepted cell request with the oldest prediction.
        function void check_cell(t_cell got);
            t_cell want;
            cells_seen++;
            if (got.kind == atw_pkg::KIND_SCROLL) scrolls_seen++;
            if (pending_cells.size() == 0) begin
                errors++;
                $display("%0t: unexpected cell request kind %0d row %0d col %0d glyph %02h",
                         $time, got.kind, got.row, got.col, got.glyph);
                return;
            end
            want = pending_cells.pop_front();
            if (got.kind !== want.kind || got.row !== want.row || got.col !== want.col ||
                got.glyph !== want.glyph || got.fg !== want.fg || got.bg !== want.bg ||
                got.last !== want.last) begin
                errors++;
                $display("%0t: cell mismatch (kind/row/col/glyph/fg/bg/last)", $time);
                $display("%0t:   expected %0d/%0d/%0d/%02h/%0d/%0d/%0d", $time,
                         want.kind, want.row, want.col, want.glyph, want.fg, want.bg,
                         want.last);
                $display("%0t:   actual   %0d/%0d/%0d/%02h/%0d/%0d/%0d", $time,
                         got.kind, got.row, got.col, got.glyph, got.fg, got.bg, got.last);
            end
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [atw_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [atw_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    atw_char_if char_bus ();
    atw_cell_if cell_bus ();

    t_screen_model board = new();
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            hold_left = 0;
    int            chars_sent = 0;

    initial begin
        char_bus.valid = 1'b0;
        char_bus.ch = '0;
        cell_bus.ready = 1'b0;
    end

    ansi_text_terminal_writer #(
        .COLUMNS    (SCREEN_COLS),
        .ROWS       (SCREEN_ROWS),
        .MAX_PARAMS (PARAM_SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_char     (char_bus),
        .o_cell     (cell_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver ready: a pending hold-off wins over random idling.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            cell_bus.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            cell_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check every accepted cell request.
    always @(posedge i_clk) begin
        if (i_rst_n && cell_bus.valid && cell_bus.ready) begin
            board.check_cell({cell_bus.kind, cell_bus.row, cell_bus.col, cell_bus.glyph,
                              cell_bus.fg_color, cell_bus.bg_color, cell_bus.last});
        end
    end

    // Offer one character request and wait for its acceptance. Returns at
    // the following falling edge with valid still high.
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            char_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        char_bus.valid <= 1'b1;
        char_bus.ch <= c;
        @(posedge i_clk);
        while (!char_bus.ready) @(posedge i_clk);
        board.take_char(c);
        chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    task automatic esc_text(input string s);
        send_char(atw_pkg::CH_ESC);
        send_text(s);
    endtask

    // Decimal parameter, now and then with a leading zero.
    task automatic send_number(input int unsigned v);
        if ($urandom_range(7) == 0) send_char(atw_pkg::CH_0);
        send_text($sformatf("%0d", v));
    endtask

    // Stop offering and wait until every predicted cell has arrived.
    task automatic drain_cells();
        int waited;
        waited = 0;
        char_bus.valid <= 1'b0;
        while (board.pending_cells.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (board.pending_cells.size() != 0) begin
            board.errors++;
            $display("%0t: %0d expected cell requests never arrived", $time,
                     board.pending_cells.size());
            board.pending_cells.delete();
        end
    endtask

    // Write both default color registers; only called while idle.
    task automatic set_colors(input logic [3:0] fg, input logic [3:0] bg);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= atw_pkg::CFG_DEFAULT_FG;
        i_cfg_data <= fg;
        @(negedge i_clk);
        board.set_default(atw_pkg::CFG_DEFAULT_FG, fg);
        i_cfg_idx <= atw_pkg::CFG_DEFAULT_BG;
        i_cfg_data <= bg;
        @(negedge i_clk);
        board.set_default(atw_pkg::CFG_DEFAULT_BG, bg);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic int unsigned pick_sgr();
        case ($urandom_range(5))
            0: return 0;
            1: return ($urandom_range(1) != 0) ? atw_pkg::SGR_FG_DEFAULT
                                               : atw_pkg::SGR_BG_DEFAULT;
            2: return $urandom_range(atw_pkg::SGR_FG_LAST, atw_pkg::SGR_FG_FIRST);
            3: return $urandom_range(atw_pkg::SGR_BG_LAST, atw_pkg::SGR_BG_FIRST);
            4: return $urandom_range(99);
            default: return $urandom_range(999);
        endcase
    endfunction

    // Positions cluster on the screen edges and beyond them.
    function automatic int unsigned pick_position();
        case ($urandom_range(9))
            0: return 0;
            1: return 1;
            2: return $urandom_range(SCREEN_ROWS, SCREEN_ROWS - 2);
            3: return $urandom_range(SCREEN_COLS, SCREEN_COLS - 2);
            4: return 255;
            5: return $urandom_range(999, 256);
            default: return $urandom_range(40);
        endcase
    endfunction

    function automatic logic [7:0] pick_control();
        case ($urandom_range(3))
            0: return atw_pkg::CH_NUL;
            1: return atw_pkg::CH_BS;
            2: return atw_pkg::CH_CR;
            default: return atw_pkg::CH_LF;
        endcase
    endfunction

    // Well-formed sequence with random parameters and final byte.
    task automatic send_sequence();
        int unsigned pick;
        int unsigned nparams;
        logic [7:0]  fin;
        pick = $urandom_range(99);
        if (pick < 30) fin = atw_pkg::CH_SGR;
        else if (pick < 45) fin = atw_pkg::CH_CUP;
        else if (pick < 55) fin = atw_pkg::CH_HVP;
        else if (pick < 62) fin = atw_pkg::CH_CUU;
        else if (pick < 69) fin = atw_pkg::CH_CUD;
        else if (pick < 76) fin = atw_pkg::CH_CUF;
        else if (pick < 83) fin = atw_pkg::CH_CUB;
        else if (pick < 92) fin = atw_pkg::CH_CHA;
        else fin = 8'($urandom_range(126, 64));
        nparams = ($urandom_range(9) == 0) ? $urandom_range(11, 3) : $urandom_range(2);
        send_char(atw_pkg::CH_ESC);
        if ($urandom_range(3) != 0) send_char(atw_pkg::CH_LBR);
        for (int i = 0; i <= nparams; i++) begin
            if (i != 0) send_char(atw_pkg::CH_SEMI);
            if ($urandom_range(9) != 0) begin
                send_number((fin == atw_pkg::CH_SGR) ? pick_sgr() : pick_position());
            end
            if ($urandom_range(19) == 0) send_char(pick_control());
        end
        send_char(fin);
    endtask

    // One random chunk of the character stream.
    task automatic random_burst();
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(99);
        if (pick < 35) begin
            n = $urandom_range(12, 1);
            repeat (n) send_char(8'($urandom_range(255, 32)));
        end else if (pick < 47) begin
            send_char(pick_control());
        end else if (pick < 85) begin
            send_sequence();
        end else if (pick < 93) begin
            // Broken sequence: random bytes, control bytes among them.
            send_char(atw_pkg::CH_ESC);
            n = $urandom_range(4, 1);
            repeat (n) begin
                send_char(($urandom_range(2) == 0) ? pick_control() : 8'($urandom_range(255)));
            end
        end else begin
            n = $urandom_range(3, 1);
            repeat (n) send_char(8'($urandom_range(255)));
        end
    endtask

    // Main stimulus.
    initial begin
        logic [3:0] fg_set [4];
        logic [3:0] bg_set [4];
        int         goal;
        bit         paused;
        bit         held;
        fg_set = '{atw_pkg::DEF_FG_RST, 4'd0, 4'd15, 4'($urandom_range(15))};
        bg_set = '{atw_pkg::DEF_BG_RST, 4'd15, 4'd9, 4'($urandom_range(15))};
        paused = 0;
        held = 0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part under the reset colors.
        send_idle_pct = 36;
        recv_idle_pct = 52;
        send_text("A");
        send_char(atw_pkg::CH_NUL);
        send_char(8'hFF);
        send_char(8'h01);
        send_char(atw_pkg::CH_BS);
        send_char(atw_pkg::CH_CR);
        esc_text("[31;42mx");
        esc_text("[37;47;30;40;29mx");
        esc_text("[39;49my");
        esc_text("[mz");
        // Home regardless of the first parameter.
        esc_text("[5Ha");
        // Cursor past the right edge on the bottom row: wrap and scroll.
        esc_text("[80;29Hb");
        esc_text("[255;255fc");
        send_char(atw_pkg::CH_LF);
        esc_text("[3A");
        esc_text("[200B");
        esc_text("[200C");
        esc_text("[5D");
        esc_text("[10Gd");
        // Parameter wrap with control bytes inside the sequence.
        esc_text("[300;2");
        send_char(atw_pkg::CH_BS);
        send_char(atw_pkg::CH_NUL);
        send_text("He");
        esc_text("[7ze");
        send_char(atw_pkg::CH_ESC);
        esc_text("[[1;2;3;4;5;6;7;8;32mf");

        // Random phases, each under its own color setting.
        for (int ph = 0; ph < 4; ph++) begin
            drain_cells();
            repeat (SETTLE_CYCLES) @(negedge i_clk);
            set_colors(fg_set[ph], bg_set[ph]);
            send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 52 : 0;
            recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 36 : 0;
            goal = chars_sent + PHASE_CHARS;
            while (chars_sent < goal) begin
                if (ph == 1 && !paused && chars_sent >= goal - PHASE_CHARS / 2) begin
                    drain_cells();
                    paused = 1;
                end
                if (ph == 2 && !held && chars_sent >= goal - PHASE_CHARS / 2) begin
                    hold_left = 400;
                    held = 1;
                end
                random_burst();
            end
        end

        drain_cells();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("Sent %0d characters under four color settings; checked %0d cell requests,",
                 chars_sent, board.cells_seen);
        $display("%0d of them scrolls, with random idling, a long receiver hold-off and a drain.",
                 board.scrolls_seen);
        if (board.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #10_000_000;
        $display("Timeout: the run did not finish in time.");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== ansi_text_terminal_writer.f =====
sv/atw_pkg.sv
sv/atw_if.sv
sv/atw_alu.sv
sv/atw_param_store.sv
sv/ansi_text_terminal_writer.sv
bench/tb_ansi_text_terminal_writer.sv
